[hw/rtl/bmp24_to_rgb565_stream_decoder_defines.svh]
// assertion macros shared by the bmp decoder rtl
`ifndef BMP24_TO_RGB565_STREAM_DECODER_DEFINES_SVH
`define BMP24_TO_RGB565_STREAM_DECODER_DEFINES_SVH

// clocked check, switched off while reset is high
`define BMP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define BMP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bmp565_pkg.sv]
// widths, codes and constants of the bmp decoder
`default_nettype none

package bmp565_pkg;

  // field widths
  localparam int DATA_W  = 8;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int COLOR_W = 16;
  localparam int KIND_W  = 1;
  localparam int ROWB_W  = 15;

  // apb port
  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 32;

  // largest accepted image side
  localparam logic [31:0] MAX_DIM = 32'd4096;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/bmp565_byte_if.sv]
// valid/ready channel carrying one file byte per word
`default_nettype none

interface bmp565_byte_if;
  import bmp565_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

[hw/rtl/bmp565_pix_if.sv]
// valid/ready channel carrying one pixel or reject result per word
`default_nettype none

interface bmp565_pix_if;
  import bmp565_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, output result_kind, output pixel_x, output pixel_y,
                  output pixel_color, input ready);
  modport sink   (input valid, input result_kind, input pixel_x, input pixel_y,
                  input pixel_color, output ready);
endinterface

`default_nettype wire

[hw/rtl/bmp24_to_rgb565_stream_decoder.sv]
// streaming 24-bit bmp parser that emits cropped rgb565 pixels
//
// file_bytes takes the bmp file one byte per word, in file order; a word with
// start_of_file high restarts parsing and counts as file byte 0.
// pixels gives one word per visible b,g,r triple (kind pixel, screen x/y and
// rgb565 colour) or a single reject word when the header is bad; nothing is
// given at all while the origin lies off screen.
// The apb port holds origin_x, origin_y, screen_width and screen_height at
// byte addresses 0, 4, 8 and 12; write them only while the stream is idle.
// Throughput: one byte per cycle while the receiver takes words. Each byte
// updates the parse counters and header fields, and its result (if any)
// lands in the output register at the same edge that takes the byte.
// The output register lets a new byte enter in the cycle its word is taken;
// while the receiver stalls with a word pending, file_bytes.ready is low.
// Reset (rst, synchronous) clears the parse state to the header phase,
// empties the output register and loads origin 0,0 and a 160x128 screen.
`default_nettype none

`include "bmp24_to_rgb565_stream_decoder_defines.svh"

module bmp24_to_rgb565_stream_decoder (
  input  wire                            clk,
  input  wire                            rst,
  bmp565_byte_if.sink                    file_bytes,
  bmp565_pix_if.source                   pixels,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [bmp565_pkg::ADDR_W-1:0]   paddr,
  input  wire [bmp565_pkg::PDATA_W-1:0]  pwdata,
  output logic [bmp565_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import bmp565_pkg::*;

  // parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_IMAGE  = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_SCREEN_W = 2'd2;
  localparam logic [1:0] REG_SCREEN_H = 2'd3;

  // header byte positions that complete a field
  localparam logic [31:0] POS_SIGNATURE = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_PLANES    = 32'd27;
  localparam logic [31:0] POS_DEPTH     = 32'd29;
  localparam logic [31:0] POS_COMPRESS  = 32'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;

  // configuration registers
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;

  // parse state
  logic [31:0]        byte_position;
  logic [1:0]         phase;
  logic [31:0]        header_word;
  logic [31:0]        image_start;
  logic [DIM_W-1:0]   image_width;
  logic               width_big;
  logic [DIM_W-1:0]   image_height;
  logic               bottom_up;
  logic [DIM_W-1:0]   file_row;
  logic [ROWB_W-1:0]  row_byte;
  logic [ROWB_W-1:0]  data_len;
  logic [ROWB_W-1:0]  row_size;
  logic [COLOR_W-1:0] color_bytes;
  logic [1:0]         byte_in_pixel;
  logic [DIM_W-1:0]   pixel_col;

  // state seen by the byte, after an optional restart
  logic [31:0]        cur_position;
  logic [1:0]         cur_phase;
  logic [31:0]        cur_header;
  logic [31:0]        cur_start;
  logic [DIM_W-1:0]   cur_width;
  logic               cur_width_big;
  logic [DIM_W-1:0]   cur_height;
  logic               cur_bottom_up;
  logic [DIM_W-1:0]   cur_row;
  logic [ROWB_W-1:0]  cur_row_byte;
  logic [ROWB_W-1:0]  cur_data_len;
  logic [ROWB_W-1:0]  cur_row_size;
  logic [COLOR_W-1:0] cur_color;
  logic [1:0]         cur_bip;
  logic [DIM_W-1:0]   cur_col;

  // next state
  logic [31:0]        byte_position_next;
  logic [1:0]         phase_next;
  logic [31:0]        header_word_next;
  logic [31:0]        image_start_next;
  logic [DIM_W-1:0]   image_width_next;
  logic               width_big_next;
  logic [DIM_W-1:0]   image_height_next;
  logic               bottom_up_next;
  logic [DIM_W-1:0]   file_row_next;
  logic [ROWB_W-1:0]  row_byte_next;
  logic [ROWB_W-1:0]  data_len_next;
  logic [ROWB_W-1:0]  row_size_next;
  logic [COLOR_W-1:0] color_bytes_next;
  logic [1:0]         byte_in_pixel_next;
  logic [DIM_W-1:0]   pixel_col_next;

  // result of the current byte
  logic               res_valid;
  logic [KIND_W-1:0]  res_kind;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;
  logic [COLOR_W-1:0] res_color;

  // helpers
  logic               on_screen;
  logic [31:0]        height_abs;
  logic [ROWB_W-1:0]  width_x3;
  logic [DIM_W-1:0]   screen_row;
  logic [DIM_W:0]     sum_x;
  logic [DIM_W:0]     sum_y;
  logic [DATA_W-1:0]  din;
  logic               acc;
  logic               cfg_wr;

  assign din = file_bytes.data_byte;
  assign acc = file_bytes.valid && file_bytes.ready;

  // a new word is taken whenever the output register is free or being emptied
  assign file_bytes.ready = !pixels.valid || pixels.ready;

  assign on_screen = ({1'b0, origin_x} < screen_width) && ({1'b0, origin_y} < screen_height);

  // restart view of the parse state
  always_comb begin
    if (file_bytes.start_of_file) begin
      cur_position  = '0;
      cur_phase     = PH_HEADER;
      cur_header    = '0;
      cur_start     = '0;
      cur_width     = '0;
      cur_width_big = 1'b0;
      cur_height    = '0;
      cur_bottom_up = 1'b1;
      cur_row       = '0;
      cur_row_byte  = '0;
      cur_data_len  = '0;
      cur_row_size  = '0;
      cur_color     = '0;
      cur_bip       = '0;
      cur_col       = '0;
    end else begin
      cur_position  = byte_position;
      cur_phase     = phase;
      cur_header    = header_word;
      cur_start     = image_start;
      cur_width     = image_width;
      cur_width_big = width_big;
      cur_height    = image_height;
      cur_bottom_up = bottom_up;
      cur_row       = file_row;
      cur_row_byte  = row_byte;
      cur_data_len  = data_len;
      cur_row_size  = row_size;
      cur_color     = color_bytes;
      cur_bip       = byte_in_pixel;
      cur_col       = pixel_col;
    end
  end

  // header field helpers on the shifted-in word
  assign height_abs = header_word_next[31] ? (32'd0 - header_word_next) : header_word_next;
  assign width_x3   = {2'b00, header_word_next[DIM_W-1:0]} +
                      {1'b0, header_word_next[DIM_W-1:0], 1'b0};

  // screen position of the pixel being completed
  assign screen_row = cur_bottom_up ? (cur_height - DIM_W'(1) - cur_row) : cur_row;
  assign sum_x      = {2'b00, origin_x} + {1'b0, cur_col};
  assign sum_y      = {2'b00, origin_y} + {1'b0, screen_row};

  // per-byte parse step
  always_comb begin
    byte_position_next = cur_position;
    phase_next         = cur_phase;
    header_word_next   = cur_header;
    image_start_next   = cur_start;
    image_width_next   = cur_width;
    width_big_next     = cur_width_big;
    image_height_next  = cur_height;
    bottom_up_next     = cur_bottom_up;
    file_row_next      = cur_row;
    row_byte_next      = cur_row_byte;
    data_len_next      = cur_data_len;
    row_size_next      = cur_row_size;
    color_bytes_next   = cur_color;
    byte_in_pixel_next = cur_bip;
    pixel_col_next     = cur_col;
    res_valid          = 1'b0;
    res_kind           = KIND_PIXEL;
    res_x              = '0;
    res_y              = '0;
    res_color          = '0;

    if (cur_phase != PH_DONE) begin
      byte_position_next = cur_position + 32'd1;
      if (cur_phase == PH_HEADER) begin
        header_word_next = {din, cur_header[31:8]};
        case (cur_position)
          POS_SIGNATURE: begin
            if (header_word_next[31:16] != BMP_SIGNATURE) begin
              phase_next = PH_DONE;
              res_valid  = on_screen;
              res_kind   = KIND_REJECT;
            end
          end
          POS_OFFSET: begin
            image_start_next = header_word_next;
          end
          POS_WIDTH: begin
            image_width_next = header_word_next[DIM_W-1:0];
            width_big_next   = header_word_next > MAX_DIM;
            data_len_next    = width_x3;
            row_size_next    = (width_x3 + ROWB_W'(3)) & ~ROWB_W'(3);
          end
          POS_HEIGHT: begin
            image_height_next = height_abs[DIM_W-1:0];
            bottom_up_next    = !header_word_next[31];
            if (cur_width_big || (height_abs > MAX_DIM)) begin
              phase_next = PH_DONE;
              res_valid  = on_screen;
              res_kind   = KIND_REJECT;
            end
          end
          POS_PLANES: begin
            if (header_word_next[31:16] != BMP_PLANES) begin
              phase_next = PH_DONE;
              res_valid  = on_screen;
              res_kind   = KIND_REJECT;
            end
          end
          POS_DEPTH: begin
            if (header_word_next[31:16] != BMP_DEPTH) begin
              phase_next = PH_DONE;
              res_valid  = on_screen;
              res_kind   = KIND_REJECT;
            end
          end
          POS_COMPRESS: begin
            if (header_word_next != 32'd0) begin
              phase_next = PH_DONE;
              res_valid  = on_screen;
              res_kind   = KIND_REJECT;
            end else if ((cur_width == '0) || (cur_height == '0)) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_IMAGE;
            end
          end
          default: begin
          end
        endcase
      end else if (cur_position >= cur_start) begin
        // pixel bytes, then row padding
        if (cur_row_byte < cur_data_len) begin
          case (cur_bip)
            2'd0: begin
              color_bytes_next   = {{(COLOR_W-DATA_W){1'b0}}, din};
              byte_in_pixel_next = 2'd1;
            end
            2'd1: begin
              color_bytes_next   = {din, cur_color[DATA_W-1:0]};
              byte_in_pixel_next = 2'd2;
            end
            default: begin
              byte_in_pixel_next = 2'd0;
              pixel_col_next     = cur_col + DIM_W'(1);
              if (on_screen && (sum_x < {1'b0, screen_width}) &&
                  (sum_y < {1'b0, screen_height})) begin
                res_valid = 1'b1;
                res_kind  = KIND_PIXEL;
                res_x     = sum_x[COORD_W-1:0];
                res_y     = sum_y[COORD_W-1:0];
                res_color = {din[7:3], cur_color[15:10], cur_color[7:3]};
              end
            end
          endcase
        end
        row_byte_next = cur_row_byte + ROWB_W'(1);
        if (row_byte_next >= cur_row_size) begin
          row_byte_next      = '0;
          byte_in_pixel_next = 2'd0;
          pixel_col_next     = '0;
          file_row_next      = cur_row + DIM_W'(1);
          if (file_row_next >= cur_height) begin
            phase_next = PH_DONE;
          end
        end
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      phase         <= PH_HEADER;
      header_word   <= '0;
      image_start   <= '0;
      image_width   <= '0;
      width_big     <= 1'b0;
      image_height  <= '0;
      bottom_up     <= 1'b1;
      file_row      <= '0;
      row_byte      <= '0;
      data_len      <= '0;
      row_size      <= '0;
      color_bytes   <= '0;
      byte_in_pixel <= '0;
      pixel_col     <= '0;
    end else if (acc) begin
      byte_position <= byte_position_next;
      phase         <= phase_next;
      header_word   <= header_word_next;
      image_start   <= image_start_next;
      image_width   <= image_width_next;
      width_big     <= width_big_next;
      image_height  <= image_height_next;
      bottom_up     <= bottom_up_next;
      file_row      <= file_row_next;
      row_byte      <= row_byte_next;
      data_len      <= data_len_next;
      row_size      <= row_size_next;
      color_bytes   <= color_bytes_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_col     <= pixel_col_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (file_bytes.ready) begin
      pixels.valid <= acc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (file_bytes.ready) begin
      pixels.result_kind <= res_kind;
      pixels.pixel_x     <= res_x;
      pixels.pixel_y     <= res_y;
      pixels.pixel_color <= res_color;
    end
  end

  // apb register writes
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      screen_width  <= DIM_W'(160);
      screen_height <= DIM_W'(128);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ORIGIN_X: origin_x      <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y: origin_y      <= pwdata[COORD_W-1:0];
        REG_SCREEN_W: screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_H: screen_height <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // apb register reads, unaligned addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_ORIGIN_X: prdata = {{(PDATA_W-COORD_W){1'b0}}, origin_x};
        REG_ORIGIN_Y: prdata = {{(PDATA_W-COORD_W){1'b0}}, origin_y};
        REG_SCREEN_W: prdata = {{(PDATA_W-DIM_W){1'b0}}, screen_width};
        REG_SCREEN_H: prdata = {{(PDATA_W-DIM_W){1'b0}}, screen_height};
        default:      prdata = '0;
      endcase
    end
  end

  // checks
  `BMP_ASSERT(a_reject_ends_file, clk, rst, (acc && res_valid && (res_kind == KIND_REJECT)) |=> (phase == PH_DONE), "reject word without parse ending")
  `BMP_ASSERT(a_row_byte_in_row, clk, rst, (phase == PH_IMAGE) |-> (row_byte < row_size), "row byte past padded row size")
  `BMP_ASSERT(a_row_in_image, clk, rst, (phase == PH_IMAGE) |-> (file_row < image_height), "file row past image height")
  `BMP_ASSERT(a_pixel_count, clk, rst, byte_in_pixel != 2'd3, "byte in pixel out of range")
  `BMP_ASSERT(a_reject_zero, clk, rst, (pixels.valid && (pixels.result_kind == KIND_REJECT)) |-> ((pixels.pixel_x == '0) && (pixels.pixel_y == '0) && (pixels.pixel_color == '0)), "reject word with nonzero payload")
  `BMP_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst) |-> !pixels.valid, "output word valid after reset")

endmodule

`default_nettype wire
